// ----- sv/pgc_pkg.sv -----
// Shared types and constants for the proximity pet gesture counter.
package pgc_pkg;

  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PROX_W  = 16;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] THRESHOLD_RST = 16'd4000;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
  localparam logic [15:0] COOLDOWN_RST  = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_TIMEOUT   = 3'd1,
    CFG_COOLDOWN  = 3'd2,
    CFG_DEBUG     = 3'd3,
    CFG_SENSOR_EN = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_ENCODER = 2'd1,
    REQ_TOGGLE  = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ARRIVED  = 3'd1,
    EV_COUNTED  = 3'd2,
    EV_REJECTED = 3'd3,
    EV_FULL     = 3'd4,
    EV_TOO_LONG = 3'd5,
    EV_OPENED   = 3'd6,
    EV_CLOSED   = 3'd7
  } event_t;

  typedef struct packed {
    logic [PROX_W-1:0] threshold;
    logic [15:0]       timeout_ms;
    logic [15:0]       cooldown_ms;
    logic              debug_mode;
    logic              sensor_enabled;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [TIME_W-1:0]        now_ms;
    logic [PROX_W-1:0]        proximity;
    logic signed [STEP_W-1:0] step_value;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] fill_level;
    logic               session_active;
    logic [2:0]         event_code;
    logic [LEVEL_W-1:0] final_level;
  } result_t;

endpackage

// ----- sv/pgc_if.sv -----
// Valid/ready channel interfaces for request and result beats.
interface pgc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic [15:0] proximity;
  logic signed [7:0] step_value;

  modport source (output valid, req_type, now_ms, proximity, step_value, input ready);
  modport sink   (input valid, req_type, now_ms, proximity, step_value, output ready);
endinterface

interface pgc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] fill_level;
  logic       session_active;
  logic [2:0] event_code;
  logic [3:0] final_level;

  modport source (output valid, fill_level, session_active, event_code, final_level,
                  input ready);
  modport sink   (input valid, fill_level, session_active, event_code, final_level,
                  output ready);
endinterface

// ----- sv/pgc_cfg_regs.sv -----
// Configuration register file with plain write port.
module pgc_cfg_regs
  import pgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_THRESHOLD: cfg_nxt.threshold      = cfg_wdata;
        CFG_TIMEOUT:   cfg_nxt.timeout_ms     = cfg_wdata;
        CFG_COOLDOWN:  cfg_nxt.cooldown_ms    = cfg_wdata;
        CFG_DEBUG:     cfg_nxt.debug_mode     = cfg_wdata[0];
        CFG_SENSOR_EN: cfg_nxt.sensor_enabled = cfg_wdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= THRESHOLD_RST;
      cfg_r.timeout_ms     <= TIMEOUT_RST;
      cfg_r.cooldown_ms    <= COOLDOWN_RST;
      cfg_r.debug_mode     <= 1'b0;
      cfg_r.sensor_enabled <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/pgc_engine.sv -----
// Session state and per-beat gesture, encoder and toggle evaluation.
module pgc_engine
  import pgc_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 10
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [LEVEL_W-1:0] MAX_LVL = LEVEL_W'(MAX_LEVEL);

  logic               session_r, session_nxt;
  logic               present_r, present_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  logic [PROX_W-1:0]  prox;
  logic [TIME_W-1:0]  held;
  logic [TIME_W-1:0]  since;
  logic signed [STEP_W:0]   step;
  logic signed [STEP_W+1:0] enc_sum;
  logic [2:0]         ev;
  logic [LEVEL_W-1:0] final_lvl;

  assign prox  = cfg.sensor_enabled ? item.proximity : '0;
  assign held  = item.now_ms - start_r;
  assign since = item.now_ms - last_r;
  assign step  = cfg.debug_mode ? {item.step_value, 1'b0}
                                : {item.step_value[STEP_W-1], item.step_value};
  assign enc_sum = $signed({{(STEP_W+2-LEVEL_W){1'b0}}, level_r})
                 + $signed({step[STEP_W], step});

  always_comb begin
    session_nxt = session_r;
    present_nxt = present_r;
    start_nxt   = start_r;
    last_nxt    = last_r;
    level_nxt   = level_r;
    ev          = EV_NONE;
    final_lvl   = '0;
    unique case (item.req_type)
      REQ_SAMPLE: begin
        if (session_r) begin
          priority if (!present_r && (prox > cfg.threshold)) begin
            present_nxt = 1'b1;
            start_nxt   = item.now_ms;
            ev          = EV_ARRIVED;
          end else if (present_r && (prox < cfg.threshold)) begin
            present_nxt = 1'b0;
            if ((held < {16'd0, cfg.timeout_ms}) && (since > {16'd0, cfg.cooldown_ms})) begin
              if (level_r < MAX_LVL) begin
                level_nxt = level_r + LEVEL_W'(1);
                last_nxt  = item.now_ms;
                ev        = EV_COUNTED;
              end else begin
                ev = EV_FULL;
              end
            end else begin
              ev = EV_REJECTED;
            end
          end else if (present_r && (held > {16'd0, cfg.timeout_ms})) begin
            present_nxt = 1'b0;
            ev          = EV_TOO_LONG;
          end else begin
            ev = EV_NONE;
          end
        end
      end
      REQ_ENCODER: begin
        if (session_r && !enc_sum[STEP_W+1]
            && (enc_sum <= $signed({{(STEP_W+2-LEVEL_W){1'b0}}, MAX_LVL}))) begin
          level_nxt = enc_sum[LEVEL_W-1:0];
        end
      end
      REQ_TOGGLE: begin
        present_nxt = 1'b0;
        if (session_r) begin
          session_nxt = 1'b0;
          final_lvl   = level_r;
          level_nxt   = '0;
          ev          = EV_CLOSED;
        end else begin
          session_nxt = 1'b1;
          last_nxt    = item.now_ms - {16'd0, cfg.cooldown_ms};
          ev          = EV_OPENED;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= 1'b0;
      present_r <= 1'b0;
      start_r   <= '0;
      last_r    <= '0;
      level_r   <= '0;
    end else if (fire) begin
      session_r <= session_nxt;
      present_r <= present_nxt;
      start_r   <= start_nxt;
      last_r    <= last_nxt;
      level_r   <= level_nxt;
    end
  end

  assign result.fill_level     = level_nxt;
  assign result.session_active = session_nxt;
  assign result.event_code     = ev;
  assign result.final_level    = final_lvl;

endmodule

// ----- sv/proximity_pet_gesture_counter_core.sv -----
// Top level: input stage, evaluation engine and result register.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------
//  in_bus   | in  | req_type, now_ms, proximity, step_value
//  out_bus  | out | fill_level, session_active, event_code, final_level
//  cfg_*    | in  | write enable, register index, 16-bit write data
//
// One beat per cycle sustained while out_bus is ready; a result passes through the input
// register, then the result register.
// The engine state updates as each beat leaves the input register into the result register.
// A stalled result holds the result register; the input register still takes one beat.
// Reset is synchronous on rst_n; it clears both stage valids and state, and restores configuration defaults.
module proximity_pet_gesture_counter_core
  import pgc_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pgc_in_if.sink                in_bus,
  pgc_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_v_r;
  result_t res;
  result_t out_res_r;
  logic    out_v_r;
  logic    advance;
  logic    take;

  assign advance = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || advance;
  assign take = in_bus.valid && in_bus.ready;

  pgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pgc_engine #(.MAX_LEVEL(MAX_LEVEL)) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (take) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r.req_type   <= in_bus.req_type;
      s1_item_r.now_ms     <= in_bus.now_ms;
      s1_item_r.proximity  <= in_bus.proximity;
      s1_item_r.step_value <= in_bus.step_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid          = out_v_r;
  assign out_bus.fill_level     = out_res_r.fill_level;
  assign out_bus.session_active = out_res_r.session_active;
  assign out_bus.event_code     = out_res_r.event_code;
  assign out_bus.final_level    = out_res_r.final_level;

endmodule

// ----- sv/pgc_checker.sv -----
// Port-level checker for the gesture counter, bound to the top level.
module pgc_checker
  import pgc_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 10
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] fill_level,
  input logic       session_active,
  input logic [2:0] event_code,
  input logic [3:0] final_level
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(fill_level)
      && $stable(event_code) && $stable(final_level) && $stable(session_active)))
    else $error("result beat changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fill_level <= 4'(MAX_LEVEL)))
    else $error("fill_level above maximum");

  a_final_only_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (final_level != 4'd0)) |-> (event_code == EV_CLOSED))
    else $error("final_level reported outside a close");

  a_close_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (event_code == EV_CLOSED)) |-> (!session_active && (fill_level == 4'd0)))
    else $error("close left session or level set");

  a_session_events: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (event_code != EV_NONE) && (event_code != EV_CLOSED)) |-> session_active)
    else $error("session event reported with no open session");

endmodule

bind proximity_pet_gesture_counter_core pgc_checker #(.MAX_LEVEL(MAX_LEVEL)) u_pgc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .fill_level     (out_bus.fill_level),
  .session_active (out_bus.session_active),
  .event_code     (out_bus.event_code),
  .final_level    (out_bus.final_level)
);
